FILE: design/cache_hit_miss_model_assert.svh
// assertion macros used by the checker file
`ifndef CACHE_HIT_MISS_MODEL_ASSERT_SVH
`define CACHE_HIT_MISS_MODEL_ASSERT_SVH

// same-cycle implication, masked while reset is applied
`define CHM_ASSERT_NOW(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("chm check failed");

// next-cycle implication, masked while reset is applied
`define CHM_ASSERT_NEXT(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("chm check failed");

// next-cycle implication that also holds across reset
`define CHM_ASSERT_ALWAYS(label, lhs, rhs) \
  label: assert property (@(posedge clk) (lhs) |=> (rhs)) \
    else $error("chm check failed");

`endif

FILE: design/chm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package chm_pkg;

  // fixed field widths
  localparam int ADDR_W    = 32;
  localparam int TAG_W     = 32;
  localparam int CNT_W     = 32;
  // set index never exceeds 15 bits (block count log2 is a 4-bit field)
  localparam int SET_W     = 15;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLK_SHIFT        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT_LOG2 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TWO_WAY          = 2'd2;

  // register reset values
  localparam logic [2:0] BLK_SHIFT_RST        = 3'd4;
  localparam logic [3:0] BLOCK_COUNT_LOG2_RST = 4'd2;
  localparam logic       TWO_WAY_RST          = 1'b0;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              end_of_trace;
  } in_item_t;

  typedef struct packed {
    logic             hit;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
  } out_item_t;

  // classified access passed from front to back
  typedef struct packed {
    logic [SET_W-1:0] set;
    logic [TAG_W-1:0] tag;
    logic             two_way;
    logic             eot;
  } job_t;

  // one tag memory row: two slots plus the set's fill toggle
  typedef struct packed {
    logic             toggle;
    logic             v1;
    logic [TAG_W-1:0] tag1;
    logic             v0;
    logic [TAG_W-1:0] tag0;
  } line_t;

endpackage

`default_nettype wire

FILE: design/cache_hit_miss_model.sv
// Cache tag lookup with hit and miss totals, direct mapped or two-way.
// Input channel in_valid/in_ready carries one read address per item, with
// end_of_trace. Result channel out_valid/out_ready returns one item per
// input: hit flag and saturating hit/miss totals of the current trace.
// Configuration (blk_shift, block_count_log2, two_way) is written through
// cfg_we/cfg_index/cfg_data; the user must write it only while the block
// is idle, and the block itself does not enforce this. The back end takes
// one item at a time: it reads the single-ported tag memory in its idle
// state and writes it in its resolve state before popping the next item.
// A two-entry queue separates the classifying front end from the lookup
// back end, so inputs keep being taken while the back end waits.
// Reset: the tag memory is swept clear, MAX_BLOCKS/2 rows (rounded down to
// a power of two); the same sweep runs after each result that
// carries end_of_trace, together with zeroing both totals. Items are queued
// during a sweep and processed after it.
// A stalled receiver holds the result in the output register; the back end
// then stops and the queue fills, after which in_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module cache_hit_miss_model #(
  parameter int MAX_BLOCKS = 1024,
  parameter int ADDR_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [chm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [chm_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire chm_pkg::in_item_t             in_item,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output chm_pkg::out_item_t                 out_item
);

  logic          q_full;
  logic          q_push;
  logic          q_pop;
  logic          q_not_empty;
  chm_pkg::job_t push_job;
  chm_pkg::job_t pop_job;

  // front end: configuration and address split
  chm_front #(
    .MAX_BLOCKS(MAX_BLOCKS),
    .ADDR_WIDTH(ADDR_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  // decoupling queue
  chm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .not_empty(q_not_empty)
  );

  // back end: tag memory, fill and totals
  chm_back #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .job_valid(q_not_empty),
    .job      (pop_job),
    .job_pop  (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

endmodule

`default_nettype wire

FILE: design/chm_front.sv
`timescale 1ns / 1ps
`default_nettype none

module chm_front #(
  parameter int MAX_BLOCKS = 1024,
  parameter int ADDR_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [chm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [chm_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire chm_pkg::in_item_t             in_item,
  input  wire logic                          q_full,
  output logic                               q_push,
  output chm_pkg::job_t                      q_job
);

  localparam int MAX_LG = $clog2(MAX_BLOCKS + 1) - 1;
  localparam logic [chm_pkg::ADDR_W-1:0] ADDR_MASK =
    (ADDR_WIDTH >= chm_pkg::ADDR_W) ? {chm_pkg::ADDR_W{1'b1}} :
    ((chm_pkg::ADDR_W'(1) << ADDR_WIDTH) - chm_pkg::ADDR_W'(1));

  logic [2:0]                  blk_shift_r;
  logic [3:0]                  block_lg_r;
  logic                        two_way_r;
  logic [chm_pkg::ADDR_W-1:0]  blk;
  logic [3:0]                  lg_nz;
  logic [3:0]                  lg_eff;
  logic [3:0]                  set_lg;
  logic [chm_pkg::ADDR_W-1:0]  set_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_shift_r <= chm_pkg::BLK_SHIFT_RST;
      block_lg_r  <= chm_pkg::BLOCK_COUNT_LOG2_RST;
      two_way_r   <= chm_pkg::TWO_WAY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        chm_pkg::REG_BLK_SHIFT:        blk_shift_r <= cfg_data[2:0];
        chm_pkg::REG_BLOCK_COUNT_LOG2: block_lg_r  <= cfg_data;
        chm_pkg::REG_TWO_WAY:          two_way_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective geometry: zero blocks acts as two, too many is clamped
  always_comb begin
    lg_nz  = (block_lg_r == 4'd0) ? 4'd1 : block_lg_r;
    lg_eff = ({1'b0, lg_nz} > 5'(MAX_LG)) ? 4'(MAX_LG) : lg_nz;
    set_lg = two_way_r ? (lg_eff - 4'd1) : lg_eff;
  end

  // split block address into set and tag
  always_comb begin
    blk      = (in_item.address & ADDR_MASK) >> blk_shift_r;
    set_full = blk & ((chm_pkg::ADDR_W'(1) << set_lg) - chm_pkg::ADDR_W'(1));
    q_job.set     = set_full[chm_pkg::SET_W-1:0];
    q_job.tag     = blk >> set_lg;
    q_job.two_way = two_way_r;
    q_job.eot     = in_item.end_of_trace;
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

endmodule

`default_nettype wire

FILE: design/chm_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module chm_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire chm_pkg::job_t push_job,
  output logic               full,
  input  wire logic          pop,
  output chm_pkg::job_t      pop_job,
  output logic               not_empty
);

  chm_pkg::job_t entry_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    count_r;
  logic [1:0]    count_nxt;

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  // occupancy tracking
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_job   = entry_r[rd_ptr_r];

endmodule

`default_nettype wire

FILE: design/chm_back.sv
`timescale 1ns / 1ps
`default_nettype none

module chm_back #(
  parameter int MAX_BLOCKS = 1024
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          job_valid,
  input  wire chm_pkg::job_t job,
  output logic               job_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output chm_pkg::out_item_t out_item
);

  localparam int MAX_LG = $clog2(MAX_BLOCKS + 1) - 1;
  localparam int ROWS   = 1 << (MAX_LG - 1);
  localparam int ROW_W  = (MAX_LG > 1) ? (MAX_LG - 1) : 1;
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

  localparam logic [1:0] ST_CLEAR   = 2'd0;
  localparam logic [1:0] ST_IDLE    = 2'd1;
  localparam logic [1:0] ST_RESOLVE = 2'd2;

  chm_pkg::line_t             mem [ROWS];
  chm_pkg::line_t             rd_line_r;
  chm_pkg::line_t             fill_line;
  chm_pkg::line_t             wr_line;
  chm_pkg::job_t              job_r;
  chm_pkg::job_t              job_nxt;
  chm_pkg::out_item_t         out_item_r;
  chm_pkg::out_item_t         out_item_nxt;
  logic [1:0]                 state_r;
  logic [1:0]                 state_nxt;
  logic [ROW_W-1:0]           clr_cnt_r;
  logic [ROW_W-1:0]           clr_cnt_nxt;
  logic [ROW_W-1:0]           rd_row;
  logic [ROW_W-1:0]           wr_row;
  logic                       rd_en;
  logic                       wr_en;
  logic                       out_load;
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic [chm_pkg::CNT_W-1:0]  hit_cnt_r;
  logic [chm_pkg::CNT_W-1:0]  hit_cnt_nxt;
  logic [chm_pkg::CNT_W-1:0]  miss_cnt_r;
  logic [chm_pkg::CNT_W-1:0]  miss_cnt_nxt;
  logic [chm_pkg::CNT_W-1:0]  hit_sum;
  logic [chm_pkg::CNT_W-1:0]  miss_sum;
  logic                       hit0;
  logic                       hit1;
  logic                       hit;

  // row of a set: two-way keeps one set per row, direct mapped packs two
  function automatic logic [ROW_W-1:0] row_of(input chm_pkg::job_t j);
    logic [chm_pkg::SET_W-1:0] s;
    s = j.two_way ? j.set : (j.set >> 1);
    return s[ROW_W-1:0];
  endfunction

  // tag memory, one row per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row] <= wr_line;
    end
    if (rd_en) begin
      rd_line_r <= mem[rd_row];
    end
  end

  // tag compare on the row just read
  always_comb begin
    hit0 = rd_line_r.v0 && (rd_line_r.tag0 == job_r.tag);
    hit1 = rd_line_r.v1 && (rd_line_r.tag1 == job_r.tag);
    if (job_r.two_way) begin
      hit = hit0 || hit1;
    end else begin
      hit = job_r.set[0] ? hit1 : hit0;
    end
  end

  // victim fill on a miss
  always_comb begin
    fill_line = rd_line_r;
    if (job_r.two_way) begin
      if (rd_line_r.toggle) begin
        fill_line.v1   = 1'b1;
        fill_line.tag1 = job_r.tag;
      end else begin
        fill_line.v0   = 1'b1;
        fill_line.tag0 = job_r.tag;
      end
      fill_line.toggle = !rd_line_r.toggle;
    end else if (job_r.set[0]) begin
      fill_line.v1   = 1'b1;
      fill_line.tag1 = job_r.tag;
    end else begin
      fill_line.v0   = 1'b1;
      fill_line.tag0 = job_r.tag;
    end
  end

  // saturating totals including this access
  always_comb begin
    hit_sum  = hit_cnt_r;
    miss_sum = miss_cnt_r;
    if (hit) begin
      if (hit_cnt_r != {chm_pkg::CNT_W{1'b1}}) begin
        hit_sum = hit_cnt_r + chm_pkg::CNT_W'(1);
      end
    end else begin
      if (miss_cnt_r != {chm_pkg::CNT_W{1'b1}}) begin
        miss_sum = miss_cnt_r + chm_pkg::CNT_W'(1);
      end
    end
    out_item_nxt.hit        = hit;
    out_item_nxt.hit_total  = hit_sum;
    out_item_nxt.miss_total = miss_sum;
  end

  // sequencer: clear sweep, read, resolve
  always_comb begin
    state_nxt    = state_r;
    clr_cnt_nxt  = clr_cnt_r;
    job_nxt      = job_r;
    job_pop      = 1'b0;
    rd_en        = 1'b0;
    rd_row       = row_of(job);
    wr_en        = 1'b0;
    wr_row       = clr_cnt_r;
    wr_line      = '0;
    out_load     = 1'b0;
    hit_cnt_nxt  = hit_cnt_r;
    miss_cnt_nxt = miss_cnt_r;
    case (state_r)
      ST_CLEAR: begin
        wr_en = 1'b1;
        if (clr_cnt_r == LAST_ROW) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + ROW_W'(1);
        end
      end
      ST_IDLE: begin
        if (job_valid) begin
          job_pop   = 1'b1;
          rd_en     = 1'b1;
          job_nxt   = job;
          state_nxt = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        if (!out_valid_r || out_ready) begin
          out_load = 1'b1;
          wr_en    = !hit;
          wr_row   = row_of(job_r);
          wr_line  = fill_line;
          if (job_r.eot) begin
            hit_cnt_nxt  = '0;
            miss_cnt_nxt = '0;
            clr_cnt_nxt  = '0;
            state_nxt    = ST_CLEAR;
          end else begin
            hit_cnt_nxt  = hit_sum;
            miss_cnt_nxt = miss_sum;
            state_nxt    = ST_IDLE;
          end
        end
      end
      default: begin
        clr_cnt_nxt = '0;
        state_nxt   = ST_CLEAR;
      end
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
      miss_cnt_r  <= miss_cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    if (out_load) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

FILE: design/chm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "cache_hit_miss_model_assert.svh"

module chm_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire chm_pkg::out_item_t out_item
);

  // a stalled result stays and holds its payload
  `CHM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item))

  // no result is offered right after reset
  `CHM_ASSERT_ALWAYS(a_reset_quiet, !rst_n, !out_valid)

  // a hit is always counted in the hit total
  `CHM_ASSERT_NOW(a_hit_counted, out_valid && out_item.hit, out_item.hit_total != 0)

  // a miss is always counted in the miss total
  `CHM_ASSERT_NOW(a_miss_counted, out_valid && !out_item.hit, out_item.miss_total != 0)

endmodule

bind cache_hit_miss_model chm_checker u_chm_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_item (out_item)
);

`default_nettype wire
